@@ rtl/core/block_bitonic_merge_sort_macros.svh @@
// Assertion macros used by the sorter's controller, bbms_ctrl.
// Depends on nothing; the including module supplies clock and reset.
`ifndef BLOCK_BITONIC_MERGE_SORT_MACROS_SVH
`define BLOCK_BITONIC_MERGE_SORT_MACROS_SVH

// Condition holds at every edge outside reset.
`define BBMS_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("check failed");

// Antecedent at one edge implies consequent at the next.
`define BBMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ rtl/core/bbms_pkg.sv @@
// Package for the merge sorter: sizes, status codes, controller/datapath command types.
// No dependencies.
package bbms_pkg;
   localparam int LANES = 16;
   localparam int DEPTH = 1024;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = AW + 1;
   localparam int LB    = $clog2(LANES);
   localparam int LCW   = $clog2(2 * LANES);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ORDER   = 2'd1;
   localparam logic [1:0] ST_COUNT   = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   typedef enum logic [1:0] {
      WR_LOAD,
      WR_LO,
      WR_HI
   } wr_src_type;

   typedef struct packed {
      logic            rd_back;
      logic [AW-1:0]   rd_addr;
      logic            ld_full;
      logic            ld_low;
      logic            cap_a;
      logic            cap_b;
      logic            cap_out;
      logic            out_zero;
      logic            sort_step;
      logic            sort_odd;
      logic            wr_en;
      logic            wr_back;
      wr_src_type      wr_src;
      logic [AW-1:0]   wr_addr;
      logic            load_val;
   } bbms_cmd_type;

   typedef struct packed {
      logic lt_prev;
      logic a_gt_b;
   } bbms_stat_type;
endpackage

@@ rtl/core/bbms_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface bbms_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] value;
   logic               last;
   modport source (output valid, mode, value, last, input ready);
   modport sink   (input valid, mode, value, last, output ready);
endinterface

interface bbms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_value;
   logic               final_res;
   logic [1:0]         status;
   modport source (output valid, sorted_value, final_res, status, input ready);
   modport sink   (input valid, sorted_value, final_res, status, output ready);
endinterface

@@ rtl/core/block_bitonic_merge_sort.sv @@
// Merge sorter for signed 32-bit values: a load gives no response; a fetch gives one
// response, through a store read, then the response register.
// After the load marked last the block is busy sorting n = LANES*2^k values: each of the
// log2(n/LANES) passes handles about n/LANES block merges, each loading LANES words
// through the one store read port, then 2*LANES odd-even sort steps, then LANES writes.
// Requests are held off while it is busy.
// Depends on bbms_pkg, bbms_if, bbms_ctrl, bbms_dp.
module block_bitonic_merge_sort import bbms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bbms_req_if.sink    req_chan,
   bbms_rsp_if.source  rsp_chan
);
   bbms_cmd_type  cmd;
   bbms_stat_type stat;

   bbms_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_mode(req_chan.mode), .req_last(req_chan.last),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_final(rsp_chan.final_res), .rsp_status(rsp_chan.status),
      .stat(stat), .cmd(cmd));

   bbms_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .load_value(req_chan.value),
      .stat(stat), .sorted_value(rsp_chan.sorted_value));
endmodule

@@ rtl/core/bbms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/bbms_dp.sv @@
// Sorter datapath: both stores, the 2*LANES merge register with its odd-even sort step,
// head compare and response data. Depends on bbms_pkg and bbms_ram.
module bbms_dp import bbms_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bbms_cmd_type       cmd,
   input  logic signed [31:0] load_value,
   output bbms_stat_type      stat,
   output logic signed [31:0] sorted_value
);
   logic signed [31:0] t_ff [2*LANES];
   logic signed [31:0] t_in [2*LANES];
   logic signed [31:0] prev_ff, prev_in;
   logic signed [31:0] head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic signed [31:0] out_ff, out_in;
   logic ld_full_ff, ld_low_ff, cap_a_ff, cap_b_ff, cap_out_ff, zero_ff, rd_back_ff;
   logic [31:0] front_rd, back_rd, wr_data;
   logic signed [31:0] rdata;

   always_comb begin
      case (cmd.wr_src)
         WR_LOAD: wr_data = load_value;
         WR_LO:   wr_data = t_ff[0];
         WR_HI:   wr_data = t_ff[LANES];
         default: wr_data = load_value;
      endcase
   end

   bbms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_front (
      .clock(clock), .wr_en(cmd.wr_en && !cmd.wr_back), .wr_addr(cmd.wr_addr),
      .wr_data(wr_data), .rd_addr(cmd.rd_addr), .rd_data(front_rd));

   bbms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_back (
      .clock(clock), .wr_en(cmd.wr_en && cmd.wr_back), .wr_addr(cmd.wr_addr),
      .wr_data(wr_data), .rd_addr(cmd.rd_addr), .rd_data(back_rd));

   assign rdata = rd_back_ff ? $signed(back_rd) : $signed(front_rd);

   always_comb begin
      t_in = t_ff;
      if (cmd.sort_step) begin
         for (int k = 0; k < 2*LANES - 1; k++) begin
            if (k[0] == cmd.sort_odd && t_ff[k] > t_ff[k+1]) begin
               t_in[k]   = t_ff[k+1];
               t_in[k+1] = t_ff[k];
            end
         end
      end else if (ld_full_ff) begin
         for (int k = 0; k < 2*LANES - 1; k++) t_in[k] = t_ff[k+1];
         t_in[2*LANES-1] = rdata;
      end else if (ld_low_ff || (cmd.wr_en && cmd.wr_src == WR_LO)) begin
         for (int k = 0; k < LANES - 1; k++) t_in[k] = t_ff[k+1];
         t_in[LANES-1] = rdata;
      end else if (cmd.wr_en && cmd.wr_src == WR_HI) begin
         for (int k = LANES; k < 2*LANES - 1; k++) t_in[k] = t_ff[k+1];
      end
   end

   always_comb begin
      prev_in   = cmd.load_val ? load_value : prev_ff;
      head_a_in = cap_a_ff ? rdata : head_a_ff;
      head_b_in = cap_b_ff ? rdata : head_b_ff;
      out_in    = out_ff;
      if (cap_out_ff) out_in = zero_ff ? 32'sd0 : rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_full_ff <= 1'b0;
         ld_low_ff  <= 1'b0;
         cap_a_ff   <= 1'b0;
         cap_b_ff   <= 1'b0;
         cap_out_ff <= 1'b0;
         zero_ff    <= 1'b0;
         rd_back_ff <= 1'b0;
         prev_ff    <= '0;
      end else begin
         ld_full_ff <= cmd.ld_full;
         ld_low_ff  <= cmd.ld_low;
         cap_a_ff   <= cmd.cap_a;
         cap_b_ff   <= cmd.cap_b;
         cap_out_ff <= cmd.cap_out;
         zero_ff    <= cmd.out_zero;
         rd_back_ff <= cmd.rd_back;
         prev_ff    <= prev_in;
      end
      t_ff      <= t_in;
      head_a_ff <= head_a_in;
      head_b_ff <= head_b_in;
      out_ff    <= out_in;
   end

   assign stat.lt_prev  = load_value < prev_ff;
   assign stat.a_gt_b   = head_a_ff > head_b_ff;
   assign sorted_value  = out_ff;
endmodule

@@ rtl/core/bbms_ctrl.sv @@
// Sorter controller: load/fetch handshake, batch counters, error code and merge sequencer.
// Depends on bbms_pkg and block_bitonic_merge_sort_macros.svh; drives bbms_dp through bbms_cmd_type.
`include "block_bitonic_merge_sort_macros.svh"
module bbms_ctrl import bbms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_mode,
   input  logic          req_last,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_final,
   output logic [1:0]    rsp_status,
   input  bbms_stat_type stat,
   output bbms_cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_INIT, S_PASS, S_PAIR, S_LOAD_A, S_LOAD_B, S_DRAIN, S_SORT,
      S_WR_LO, S_PICK, S_CMP_A, S_CMP_B, S_CMP_WAIT, S_CMP_SEL, S_LOAD_ONE, S_WR_HI
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, rd_idx_ff, rd_idx_in, len_ff, len_in;
   logic [CNT_W-1:0] run_ff, run_in, base_ff, base_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [CNT_W-1:0] mid_ff, mid_in, end_ff, end_in, out_ff, out_in, sel_ff, sel_in;
   logic [LCW-1:0]   cnt_ff, cnt_in;
   logic [1:0]       err_ff, err_in, status_ff, status_in;
   logic ready_ff, ready_in, in_back_ff, in_back_in, res_back_ff, res_back_in;
   logic rsp_valid_ff, rsp_valid_in, final_ff, final_in;
   logic accept, lane_last, sort_last, empty;
   logic [CNT_W-1:0] eff_cnt, n_calc, rd_ptr;
   logic [1:0]       eff_err;

   assign accept    = req_valid && req_ready;
   assign lane_last = cnt_ff == LCW'(LANES - 1);
   assign sort_last = cnt_ff == LCW'(2*LANES - 1);
   assign eff_cnt   = ready_ff ? '0 : count_ff;
   assign eff_err   = ready_ff ? ST_OK : err_ff;
   assign empty     = !ready_ff || rd_idx_ff >= len_ff;

   always_comb begin
      n_calc = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (count_ff[b]) n_calc = CNT_W'(1) << b;
      end
      if (n_calc < CNT_W'(LANES)) n_calc = '0;
   end

   always_comb begin
      case (state_ff)
         S_LOAD_A:   rd_ptr = p1_ff + CNT_W'(cnt_ff);
         S_LOAD_B:   rd_ptr = p2_ff + CNT_W'(cnt_ff);
         S_LOAD_ONE: rd_ptr = sel_ff + CNT_W'(cnt_ff);
         S_CMP_A:    rd_ptr = p1_ff;
         S_CMP_B:    rd_ptr = p2_ff;
         default:    rd_ptr = rd_idx_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  rd_idx_in = rd_idx_ff;  len_in = len_ff;
      run_in = run_ff;  base_in = base_ff;  p1_in = p1_ff;  p2_in = p2_ff;
      mid_in = mid_ff;  end_in = end_ff;  out_in = out_ff;  sel_in = sel_ff;
      cnt_in = cnt_ff;  err_in = err_ff;  status_in = status_ff;  ready_in = ready_ff;
      in_back_in = in_back_ff;  res_back_in = res_back_ff;  final_in = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd = '0;
      cmd.rd_addr = rd_ptr[AW-1:0];
      cmd.rd_back = (state_ff == S_IDLE) ? res_back_ff : in_back_ff;
      cmd.wr_back = !in_back_ff;
      cmd.wr_addr = out_ff[AW-1:0];
      cmd.sort_odd = cnt_ff[0];

      case (state_ff)
         S_IDLE: begin
            if (accept && req_mode == MODE_LOAD) begin
               cmd.wr_src = WR_LOAD;
               cmd.wr_back = 1'b0;
               cmd.wr_addr = eff_cnt[AW-1:0];
               rd_idx_in = ready_ff ? '0 : rd_idx_ff;
               len_in = ready_ff ? '0 : len_ff;
               ready_in = 1'b0;
               err_in = eff_err;
               count_in = eff_cnt;
               if (eff_cnt < CNT_W'(DEPTH)) begin
                  if (eff_cnt[LB-1:0] != '0 && stat.lt_prev && eff_err == ST_OK)
                     err_in = ST_ORDER;
                  cmd.wr_en = 1'b1;
                  cmd.load_val = 1'b1;
                  count_in = eff_cnt + CNT_W'(1);
               end else begin
                  err_in = ST_COUNT;
               end
               if (req_last) state_in = S_INIT;
            end else if (accept) begin
               cmd.cap_out = 1'b1;
               cmd.out_zero = empty;
               final_in = !empty && (rd_idx_ff + CNT_W'(1) == len_ff);
               status_in = empty ? ST_EMPTY : err_ff;
               if (!empty) rd_idx_in = rd_idx_ff + CNT_W'(1);
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_INIT: begin
            len_in = n_calc;
            if (n_calc != count_ff) err_in = ST_COUNT;
            run_in = CNT_W'(LANES);
            in_back_in = 1'b0;
            state_in = S_PASS;
         end
         S_PASS: begin
            if (run_ff < len_ff) begin
               base_in = '0;
               out_in = '0;
               state_in = S_PAIR;
            end else begin
               res_back_in = in_back_ff;
               rd_idx_in = '0;
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PAIR: begin
            cnt_in = '0;
            if (base_ff < len_ff) begin
               p1_in = base_ff;
               mid_in = base_ff + run_ff;
               p2_in = base_ff + run_ff;
               end_in = base_ff + (run_ff << 1);
               state_in = S_LOAD_A;
            end else begin
               run_in = run_ff << 1;
               in_back_in = !in_back_ff;
               state_in = S_PASS;
            end
         end
         S_LOAD_A: begin
            cmd.ld_full = 1'b1;
            cnt_in = cnt_ff + LCW'(1);
            if (lane_last) begin
               cnt_in = '0;
               p1_in = p1_ff + CNT_W'(LANES);
               state_in = S_LOAD_B;
            end
         end
         S_LOAD_B: begin
            cmd.ld_full = 1'b1;
            cnt_in = cnt_ff + LCW'(1);
            if (lane_last) begin
               cnt_in = '0;
               p2_in = p2_ff + CNT_W'(LANES);
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cnt_in = '0;
            state_in = S_SORT;
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            cnt_in = cnt_ff + LCW'(1);
            if (sort_last) begin
               cnt_in = '0;
               state_in = S_WR_LO;
            end
         end
         S_WR_LO: begin
            cmd.wr_en = 1'b1;
            cmd.wr_src = WR_LO;
            out_in = out_ff + CNT_W'(1);
            cnt_in = cnt_ff + LCW'(1);
            if (lane_last) begin
               cnt_in = '0;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (p1_ff < mid_ff && p2_ff < end_ff) begin
               state_in = S_CMP_A;
            end else if (p1_ff < mid_ff) begin
               sel_in = p1_ff;
               p1_in = p1_ff + CNT_W'(LANES);
               state_in = S_LOAD_ONE;
            end else if (p2_ff < end_ff) begin
               sel_in = p2_ff;
               p2_in = p2_ff + CNT_W'(LANES);
               state_in = S_LOAD_ONE;
            end else begin
               state_in = S_WR_HI;
            end
         end
         S_CMP_A: begin
            cmd.cap_a = 1'b1;
            state_in = S_CMP_B;
         end
         S_CMP_B: begin
            cmd.cap_b = 1'b1;
            state_in = S_CMP_WAIT;
         end
         S_CMP_WAIT: state_in = S_CMP_SEL;
         S_CMP_SEL: begin
            if (stat.a_gt_b) begin
               sel_in = p2_ff;
               p2_in = p2_ff + CNT_W'(LANES);
            end else begin
               sel_in = p1_ff;
               p1_in = p1_ff + CNT_W'(LANES);
            end
            state_in = S_LOAD_ONE;
         end
         S_LOAD_ONE: begin
            cmd.ld_low = 1'b1;
            cnt_in = cnt_ff + LCW'(1);
            if (lane_last) begin
               cnt_in = '0;
               state_in = S_DRAIN;
            end
         end
         S_WR_HI: begin
            cmd.wr_en = 1'b1;
            cmd.wr_src = WR_HI;
            out_in = out_ff + CNT_W'(1);
            cnt_in = cnt_ff + LCW'(1);
            if (lane_last) begin
               cnt_in = '0;
               base_in = base_ff + (run_ff << 1);
               state_in = S_PAIR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  count_ff <= '0;  rd_idx_ff <= '0;  len_ff <= '0;
         run_ff <= '0;  base_ff <= '0;  p1_ff <= '0;  p2_ff <= '0;  mid_ff <= '0;
         end_ff <= '0;  out_ff <= '0;  sel_ff <= '0;  cnt_ff <= '0;  err_ff <= ST_OK;
         status_ff <= ST_OK;  ready_ff <= 1'b0;  in_back_ff <= 1'b0;
         res_back_ff <= 1'b0;  rsp_valid_ff <= 1'b0;  final_ff <= 1'b0;
         req_ready <= 1'b0;
      end else begin
         state_ff <= state_in;  count_ff <= count_in;  rd_idx_ff <= rd_idx_in;
         len_ff <= len_in;  run_ff <= run_in;  base_ff <= base_in;  p1_ff <= p1_in;
         p2_ff <= p2_in;  mid_ff <= mid_in;  end_ff <= end_in;  out_ff <= out_in;
         sel_ff <= sel_in;  cnt_ff <= cnt_in;  err_ff <= err_in;  status_ff <= status_in;
         ready_ff <= ready_in;  in_back_ff <= in_back_in;  res_back_ff <= res_back_in;
         rsp_valid_ff <= rsp_valid_in;  final_ff <= final_in;
         req_ready <= state_in == S_IDLE && !rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_final  = final_ff;
   assign rsp_status = status_ff;

   `BBMS_ASSERT(a_len_fits, !ready_ff || len_ff <= count_ff)
   `BBMS_ASSERT(a_rd_in_len, !ready_ff || rd_idx_ff <= len_ff)
   `BBMS_ASSERT(a_run_ptrs, p1_ff <= mid_ff && p2_ff <= end_ff)
   `BBMS_ASSERT(a_no_accept_busy, !(req_ready && rsp_valid_ff))
   `BBMS_ASSERT_NEXT(a_fetch_rsp, state_ff == S_FETCH, rsp_valid_ff)
endmodule
